[design/bm32_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm32_pkg
// Types and constants shared by the binary32 multiplier pipeline.
// ----------------------------------------------------------------------------
package bm32_pkg;

    localparam int FlagInexact   = 0;
    localparam int FlagUnderflow = 1;
    localparam int FlagOverflow  = 2;
    localparam int FlagInvalid   = 3;

    localparam logic [30:0] MAG_INF      = 31'h7F800000;
    localparam logic [31:0] QUIET_BIT    = 32'h00400000;
    localparam logic [7:0]  EXP_ALL_ONES = 8'hFF;
    localparam logic signed [9:0] EXP_OFFSET = 10'sd110;
    localparam logic signed [9:0] EXP_TOP    = 10'sd254;
    localparam logic signed [9:0] D_MIN      = -10'sd24;

    typedef struct packed {
        logic [31:0] operand_a;
        logic [31:0] operand_b;
    } bm32_in_t;

    typedef struct packed {
        logic [31:0] product;
        logic [3:0]  exception_flags;
    } bm32_out_t;

    // after unpack
    typedef struct packed {
        logic              sign;
        logic              special;
        logic [31:0]       spec_res;
        logic [3:0]        spec_flags;
        logic [23:0]       sig_a;
        logic [23:0]       sig_b;
        logic signed [9:0] exp_base;
    } bm32_s1_t;

    // after multiply
    typedef struct packed {
        logic              sign;
        logic              special;
        logic [31:0]       spec_res;
        logic [3:0]        spec_flags;
        logic [47:0]       prod;
        logic signed [9:0] exp_base;
    } bm32_s2_t;

    // after alignment
    typedef struct packed {
        logic        sign;
        logic        early;
        logic [31:0] early_res;
        logic [3:0]  early_flags;
        logic [7:0]  exp;
        logic [23:0] mant;
        logic        guard;
        logic        sticky;
    } bm32_s3_t;

endpackage

[design/bm32_unpack.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm32_unpack
// Special-operand handling, subnormal normalization and exponent base.
// ----------------------------------------------------------------------------
module bm32_unpack (
    input  bm32_pkg::bm32_in_t in_data,
    output bm32_pkg::bm32_s1_t out_data
);
    import bm32_pkg::*;

    function automatic logic [4:0] lz23(input logic [22:0] f);
        logic [4:0] n;
        n = 5'd23;
        for (int i = 0; i < 23; i++) begin
            if (f[i]) begin
                n = 5'(22 - i);
            end
        end
        return n;
    endfunction

    logic [30:0] mag_a, mag_b, mag_mn, mag_mx;
    logic        sign;
    logic        nan_case, snan_a, snan_b, zero_inf;
    logic [4:0]  lz_a, lz_b;
    logic signed [9:0] eadj_a, eadj_b;

    assign mag_a  = in_data.operand_a[30:0];
    assign mag_b  = in_data.operand_b[30:0];
    assign sign   = in_data.operand_a[31] ^ in_data.operand_b[31];
    assign mag_mn = (mag_a < mag_b) ? mag_a : mag_b;
    assign mag_mx = (mag_a > mag_b) ? mag_a : mag_b;
    assign lz_a   = lz23(mag_a[22:0]);
    assign lz_b   = lz23(mag_b[22:0]);

    assign zero_inf = (mag_mn == '0) && (mag_mx == MAG_INF);
    assign nan_case = (mag_mx > MAG_INF) || zero_inf;
    assign snan_a   = (mag_a > MAG_INF) && !in_data.operand_a[22];
    assign snan_b   = (mag_b > MAG_INF) && !in_data.operand_b[22];

    // exponent minus normalization shift; normal: e-9, subnormal: -(9+lz)
    assign eadj_a = (mag_a[30:23] != '0) ? ($signed({2'b00, mag_a[30:23]}) - 10'sd9)
                                         : -$signed({5'b0, lz_a} + 10'd9);
    assign eadj_b = (mag_b[30:23] != '0) ? ($signed({2'b00, mag_b[30:23]}) - 10'sd9)
                                         : -$signed({5'b0, lz_b} + 10'd9);

    always_comb begin
        out_data            = '0;
        out_data.sign       = sign;
        out_data.special    = (mag_mn == '0) || (mag_mx >= MAG_INF);
        out_data.spec_flags = '0;
        if (nan_case) begin
            out_data.spec_res = {sign, MAG_INF} | QUIET_BIT | {1'b0, mag_mx};
            out_data.spec_flags[FlagInvalid] = snan_a || snan_b || zero_inf;
        end else if (mag_mx != MAG_INF) begin
            out_data.spec_res = {sign, 31'b0};
        end else begin
            out_data.spec_res = {sign, MAG_INF};
        end
        out_data.sig_a = (mag_a[30:23] != '0) ? {1'b1, mag_a[22:0]}
                                              : 24'({mag_a[22:0], 1'b0} << lz_a);
        out_data.sig_b = (mag_b[30:23] != '0) ? {1'b1, mag_b[22:0]}
                                              : 24'({mag_b[22:0], 1'b0} << lz_b);
        out_data.exp_base = eadj_a + eadj_b - EXP_OFFSET;
    end

endmodule

[design/bm32_align.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm32_align
// Exponent range checks and right shift of the product to its final place.
// ----------------------------------------------------------------------------
module bm32_align (
    input  bm32_pkg::bm32_s2_t in_data,
    output bm32_pkg::bm32_s3_t out_data
);
    import bm32_pkg::*;

    logic              top;
    logic signed [9:0] d0;
    logic [4:0]        shamt;
    logic [47:0]       shifted;
    logic [47:0]       low_mask;

    assign top = in_data.prod[47];
    assign d0  = in_data.exp_base + $signed({9'b0, top});

    always_comb begin
        if (d0 < 0) begin
            shamt = 5'(-d0) + {4'b0, top};
        end else begin
            shamt = {4'b0, top};
        end
    end

    assign shifted  = in_data.prod >> shamt;
    assign low_mask = (48'd1 << (6'd22 + {1'b0, shamt})) - 48'd1;

    always_comb begin
        out_data             = '0;
        out_data.sign        = in_data.sign;
        out_data.exp         = (d0 < 0) ? 8'd0 : d0[7:0];
        out_data.mant        = shifted[46:23];
        out_data.guard       = shifted[22];
        out_data.sticky      = |(in_data.prod & low_mask);
        out_data.early_flags = '0;
        if (in_data.special) begin
            out_data.early       = 1'b1;
            out_data.early_res   = in_data.spec_res;
            out_data.early_flags = in_data.spec_flags;
        end else if (d0 < D_MIN) begin
            // below half the smallest subnormal
            out_data.early     = 1'b1;
            out_data.early_res = {in_data.sign, 31'b0};
            out_data.early_flags[FlagUnderflow] = 1'b1;
            out_data.early_flags[FlagInexact]   = 1'b1;
        end else if (d0 >= EXP_TOP) begin
            out_data.early     = 1'b1;
            out_data.early_res = {in_data.sign, MAG_INF};
            out_data.early_flags[FlagOverflow] = 1'b1;
            out_data.early_flags[FlagInexact]  = 1'b1;
        end else begin
            out_data.early     = 1'b0;
            out_data.early_res = '0;
        end
    end

endmodule

[design/bm32_round.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm32_round
// Round to nearest even, pack the result and raise the flags.
// ----------------------------------------------------------------------------
module bm32_round (
    input  bm32_pkg::bm32_s3_t  in_data,
    output bm32_pkg::bm32_out_t out_data
);
    import bm32_pkg::*;

    logic        inc, inexact;
    logic [31:0] z;

    assign inc     = in_data.guard & (in_data.mant[0] | in_data.sticky);
    assign inexact = in_data.guard | in_data.sticky;
    // hidden bit of mant carries into the exponent field
    assign z = {in_data.sign, in_data.exp, 23'b0} + {8'b0, in_data.mant}
             + {31'b0, inc};

    always_comb begin
        out_data = '0;
        if (in_data.early) begin
            out_data.product         = in_data.early_res;
            out_data.exception_flags = in_data.early_flags;
        end else begin
            out_data.product = z;
            out_data.exception_flags[FlagInexact]   = inexact;
            out_data.exception_flags[FlagUnderflow] = inexact & !in_data.mant[23];
            out_data.exception_flags[FlagOverflow]  = (z[30:23] == EXP_ALL_ONES);
        end
    end

endmodule

[design/binary32_multiplier.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary32_multiplier
// IEEE 754 single-precision multiply, round to nearest even, per-beat flags.
// ----------------------------------------------------------------------------
//  channel | dir | payload                          | handshake
//  s_      | in  | operand_a, operand_b             | s_valid / s_ready
//  m_      | out | product, exception_flags         | m_valid / m_ready
//
// Four register stages: unpack, 24x24 multiply, align, round. A beat passes
// through all four registers to m_valid; one beat per cycle while m_ready is high.
// Each stage advances when it is empty or the next stage advances, so
// bubbles are squeezed out under a stall and nothing is dropped.
// Synchronous active-low reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
module binary32_multiplier (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bm32_pkg::bm32_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output bm32_pkg::bm32_out_t m_data
);
    import bm32_pkg::*;

    bm32_s1_t  s1_next, s1_reg;
    bm32_s2_t  s2_next, s2_reg;
    bm32_s3_t  s3_next, s3_reg;
    bm32_out_t s4_next, s4_reg;
    logic      v1_reg, v2_reg, v3_reg, v4_reg;
    logic      rdy1, rdy2, rdy3, rdy4;

    assign rdy4    = !v4_reg || m_ready;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;
    assign m_valid = v4_reg;
    assign m_data  = s4_reg;

    bm32_unpack u_unpack (.in_data(s_data), .out_data(s1_next));

    always_comb begin
        s2_next            = '0;
        s2_next.sign       = s1_reg.sign;
        s2_next.special    = s1_reg.special;
        s2_next.spec_res   = s1_reg.spec_res;
        s2_next.spec_flags = s1_reg.spec_flags;
        s2_next.exp_base   = s1_reg.exp_base;
        s2_next.prod       = {24'b0, s1_reg.sig_a} * {24'b0, s1_reg.sig_b};
    end

    bm32_align u_align (.in_data(s2_reg), .out_data(s3_next));
    bm32_round u_round (.in_data(s3_reg), .out_data(s4_next));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && s_valid) s1_reg <= s1_next;
        if (rdy2 && v1_reg)  s2_reg <= s2_next;
        if (rdy3 && v2_reg)  s3_reg <= s3_next;
        if (rdy4 && v3_reg)  s4_reg <= s4_next;
    end

    a_full_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v1_reg && v2_reg && v3_reg && v4_reg))
        else $error("input blocked with a bubble in the pipe");

    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> v1_reg)
        else $error("accepted beat lost at stage 1");

    a_invalid_nan: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.exception_flags[FlagInvalid]) |->
        (m_data.product[30:22] == 9'h1FF))
        else $error("invalid without quiet NaN");

    a_ovf_inexact: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.exception_flags[FlagOverflow]) |->
        m_data.exception_flags[FlagInexact])
        else $error("overflow without inexact");

    a_unf_inexact: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.exception_flags[FlagUnderflow]) |->
        m_data.exception_flags[FlagInexact])
        else $error("underflow without inexact");

endmodule

[test/binary32_multiplier_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary32_multiplier_tb
// Drives operand pairs through the multiplier with random idling on both
// sides, predicts each product and flag set, and compares them in order.
// ----------------------------------------------------------------------------
module binary32_multiplier_tb;
    import bm32_pkg::*;

    localparam int NumRandom = 1450;
    localparam int CycleLimit = 200000;
    localparam int Latency = 4;

    localparam logic [31:0] MaxFinite = 32'h7F7FFFFF;
    localparam logic [31:0] InfMag    = 32'h7F800000;
    localparam logic [31:0] MagMask   = 32'h7FFFFFFF;
    localparam logic [31:0] SignBit   = 32'h80000000;
    localparam logic [31:0] MinNormal = 32'h00800000;
    localparam int          ExpBias   = 110;
    localparam int          ExpMax    = 254;

    localparam logic [3:0] FInexact   = 4'(1 << FlagInexact);
    localparam logic [3:0] FUnderflow = 4'(1 << FlagUnderflow);
    localparam logic [3:0] FOverflow  = 4'(1 << FlagOverflow);
    localparam logic [3:0] FInvalid   = 4'(1 << FlagInvalid);

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    bm32_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    bm32_out_t m_data;

    bm32_out_t product_queue[$];
    int        mismatches = 0;
    int        cycles = 0;
    bit        stim_done = 1'b0;

    binary32_multiplier u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int count_lz(logic [31:0] v);
        int n;
        n = 0;
        if (v == 0) return 32;
        while (!v[31]) begin
            n++;
            v = v << 1;
        end
        return n;
    endfunction

    function automatic bm32_out_t predict_product(logic [31:0] a, logic [31:0] b);
        bm32_out_t r;
        logic [31:0] ma, mb, lo_mag, hi_mag, sgn, inf_res, fa, fb, hi, lo, mant;
        logic [63:0] prod;
        int sa, sb, carry, ediff;
        logic guard, sticky, rnd;
        r.exception_flags = '0;
        ma = a & MagMask;
        mb = b & MagMask;
        sgn = (a ^ b) & SignBit;
        inf_res = sgn | InfMag;
        lo_mag = (ma < mb) ? ma : mb;
        hi_mag = (ma > mb) ? ma : mb;
        if (lo_mag == 0 || hi_mag >= InfMag) begin
            if (hi_mag > InfMag || (lo_mag == 0 && hi_mag == InfMag)) begin
                if ((ma > InfMag && !a[22]) || (mb > InfMag && !b[22])
                        || (lo_mag == 0 && hi_mag == InfMag))
                    r.exception_flags |= FInvalid;
                r.product = inf_res | QUIET_BIT | hi_mag;
            end else begin
                r.product = (hi_mag != InfMag) ? sgn : inf_res;
            end
            return r;
        end
        sa = count_lz(ma); if (sa < 8) sa = 8;
        sb = count_lz(mb); if (sb < 8) sb = 8;
        fa = (a << sa) | SignBit;
        fb = (b << sb) | SignBit;
        prod = 64'(fa) * 64'(fb);
        hi = prod[63:32];
        lo = prod[31:0];
        carry = hi[31];
        ediff = (int'(ma >> 23) - int'(ma >= MinNormal)) + (int'(mb >> 23) - int'(mb >= MinNormal))
              - (sa + sb + ExpBias) + carry;
        if (ediff < 0) begin
            if (ediff < -24) begin
                r.exception_flags = FUnderflow | FInexact;
                r.product = sgn;
                return r;
            end
            carry += -ediff;
            ediff = 0;
        end else if (ediff >= ExpMax) begin
            r.exception_flags = FOverflow | FInexact;
            r.product = inf_res;
            return r;
        end
        guard = hi[6 + carry];
        mant = (carry >= 25) ? 32'd0 : (hi >> (7 + carry));
        sticky = (lo != 0) || ((hi << (26 - carry)) != 0);
        rnd = guard & (mant[0] | sticky);
        if (guard | sticky) begin
            r.exception_flags |= FInexact;
            if (mant < MinNormal) r.exception_flags |= FUnderflow;
        end
        r.product = (sgn | (32'(ediff) << 23)) + mant + 32'(rnd);
        if (r.product[30:23] == EXP_ALL_ONES) r.exception_flags |= FOverflow;
        return r;
    endfunction

    // directed rows; check_row marks an expectation typed in by hand
    typedef struct {
        logic [31:0] a;
        logic [31:0] b;
        bit          check_row;
        logic [31:0] p;
        logic [3:0]  f;
    } row_t;

    row_t directed[] = '{
        '{32'h3F800000, 32'h3F800000, 1, 32'h3F800000, 4'h0},
        '{32'h00000000, 32'h80000000, 1, 32'h80000000, 4'h0},
        '{32'h7F800000, 32'h00000000, 1, 32'h7FC00000, FInvalid},
        '{32'h80000000, 32'h7F800000, 1, 32'hFFC00000, FInvalid},
        '{32'h7F800000, 32'hBF800000, 1, 32'hFF800000, 4'h0},
        '{32'h7FC00001, 32'h3F800000, 1, 32'h7FC00001, 4'h0},
        '{32'h7F800001, 32'h3F800000, 1, 32'h7FC00001, FInvalid},
        '{32'hFFFFFFFF, 32'h7F800001, 0, 0, 0},
        '{MaxFinite,    MaxFinite,    1, 32'h7F800000, FOverflow | FInexact},
        '{32'h00000001, 32'h00000001, 1, 32'h00000000, FUnderflow | FInexact},
        '{32'h00000001, 32'h3F800000, 0, 0, 0},
        '{32'h00000001, 32'h3F000000, 0, 0, 0},
        '{32'h00000003, 32'h3F000000, 0, 0, 0},
        '{32'h007FFFFF, 32'h3F800001, 0, 0, 0},
        '{32'h00800000, 32'h3F7FFFFF, 0, 0, 0},
        '{32'h7F7FFFFF, 32'h3F800001, 0, 0, 0},
        '{32'h3FFFFFFF, 32'h3FFFFFFF, 0, 0, 0},
        '{32'h00400000, 32'h4B000000, 0, 0, 0},
        '{32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0},
        '{32'h80000001, 32'h7F7FFFFF, 0, 0, 0},
        '{32'h3FC00000, 32'h00000003, 0, 0, 0}
    };

    function automatic logic [31:0] random_operand();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(0, 9))
            0: v[30:23] = 8'h00;
            1: v[30:23] = 8'hFF;
            2: v[30:0]  = $urandom_range(0, 3) == 0 ? 31'h0 : 31'(InfMag);
            3: v[30:23] = 8'($urandom_range(0, 24));
            4: v[30:23] = 8'($urandom_range(230, 254));
            default: v[30:23] = 8'($urandom_range(90, 165));
        endcase
        return v;
    endfunction

    // called at a falling edge; returns at the falling edge after the accept
    task automatic send_operands(logic [31:0] a, logic [31:0] b, bm32_out_t exp_res);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        product_queue.push_back(exp_res);
        s_data <= '{operand_a: a, operand_b: b};
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    initial begin
        bm32_out_t e;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        foreach (directed[i]) begin
            e = predict_product(directed[i].a, directed[i].b);
            if (directed[i].check_row) begin
                e.product = directed[i].p;
                e.exception_flags = directed[i].f;
            end
            send_operands(directed[i].a, directed[i].b, e);
        end
        s_valid <= 1'b0;
        // drain fully once before the random part
        wait (product_queue.size() == 0);
        @(negedge aclk);
        for (int i = 0; i < NumRandom; i++) begin
            logic [31:0] a, b;
            a = random_operand();
            b = random_operand();
            send_operands(a, b, predict_product(a, b));
        end
        s_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // result side: random stalls, with long stall-free stretches
    initial begin
        int wait_cycles;
        forever begin
            @(negedge aclk);
            if ((cycles / 500) % 3 == 2) begin
                m_ready <= 1'b1;
            end else begin
                wait_cycles = $urandom_range(0, 7);
                if (wait_cycles > 0) begin
                    m_ready <= 1'b0;
                    repeat (wait_cycles) @(negedge aclk);
                end
                m_ready <= 1'b1;
                @(posedge aclk);
                while (!m_valid) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        bm32_out_t e;
        cycles <= cycles + 1;
        if (aresetn && m_valid && m_ready) begin
            if (product_queue.size() == 0) begin
                $error("unexpected beat: product %h flags %h",
                       m_data.product, m_data.exception_flags);
                mismatches++;
            end else begin
                e = product_queue.pop_front();
                if (m_data.product !== e.product) begin
                    $error("product: expected %h actual %h", e.product, m_data.product);
                    mismatches++;
                end
                if (m_data.exception_flags !== e.exception_flags) begin
                    $error("exception_flags: expected %h actual %h",
                           e.exception_flags, m_data.exception_flags);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        wait (stim_done && product_queue.size() == 0);
        repeat (Latency * 4) @(posedge aclk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        wait (cycles >= CycleLimit);
        $display("Verification failed");
        $finish;
    end

endmodule
